// ===== src/orientation_matrix_axis_rotator_macros.svh =====
// Assertion macros for the orientation matrix axis rotator
`ifndef ORIENTATION_MATRIX_AXIS_ROTATOR_MACROS_SVH
`define ORIENTATION_MATRIX_AXIS_ROTATOR_MACROS_SVH
`ifndef SYNTHESIS
`define OMR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define OMR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define OMR_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define OMR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/omr_pkg.sv =====
// ----------------------------------------------------------------------------
// omr_pkg
// Shared types, constants and the arctangent table for the axis rotator.
// ----------------------------------------------------------------------------
package omr_pkg;
  localparam int ElemWidthDefault = 18;
  localparam int FracBits = 16;
  localparam int CordicSteps = 16;
  localparam int StepW = 4;
  localparam int TrigW = 20;
  localparam logic signed [TrigW-1:0] CordicGain = 20'sd39797;
  localparam logic signed [TrigW-1:0] OneQ16 = 20'sd65536;

  typedef enum logic [1:0] {
    MODE_PITCH = 2'd0,
    MODE_YAW   = 2'd1,
    MODE_ROLL  = 2'd2,
    MODE_IDENT = 2'd3
  } mode_t;

  // Command handed from the front end to the back end
  typedef struct packed {
    mode_t                    mode;
    logic signed [TrigW-1:0]  sin_v;
    logic signed [TrigW-1:0]  cos_v;
  } cmd_t;

  function automatic logic signed [TrigW-1:0] atan_lut(input logic [StepW-1:0] i);
    logic signed [TrigW-1:0] v;
    case (i)
      4'd0:  v = 20'sd8192;
      4'd1:  v = 20'sd4836;
      4'd2:  v = 20'sd2555;
      4'd3:  v = 20'sd1297;
      4'd4:  v = 20'sd651;
      4'd5:  v = 20'sd326;
      4'd6:  v = 20'sd163;
      4'd7:  v = 20'sd81;
      4'd8:  v = 20'sd41;
      4'd9:  v = 20'sd20;
      4'd10: v = 20'sd10;
      4'd11: v = 20'sd5;
      4'd12: v = 20'sd3;
      4'd13: v = 20'sd1;
      4'd14: v = 20'sd1;
      default: v = 20'sd0;
    endcase
    return v;
  endfunction
endpackage

// ===== src/omr_front.sv =====
// ----------------------------------------------------------------------------
// omr_front
// Accepts commands and runs an iterative CORDIC, one step per cycle; identity commands skip it.
// ----------------------------------------------------------------------------
module omr_front import omr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_mode,
  input  logic signed [15:0] in_rotation_angle,
  output logic               cmd_valid,
  output cmd_t               cmd_data,
  input  logic               cmd_stall
);
  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_RUN  = 3'b010,
    F_DONE = 3'b100
  } fstate_t;

  fstate_t state_r, state_nxt;
  logic [StepW-1:0] step_r, step_nxt;
  logic signed [TrigW-1:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic flip_r, flip_nxt;
  mode_t mode_r, mode_nxt;
  logic signed [15:0] ang;
  logic signed [16:0] red;
  logic flip_in;
  logic signed [TrigW-1:0] dx, dy, xf, yf, cs, sn;

  always_comb begin
    // pitch and roll use the negated angle; -32768 wraps to itself
    ang = (in_mode == MODE_YAW) ? in_rotation_angle : 16'(-in_rotation_angle);
    flip_in = 1'b0;
    red = 17'(ang);
    if (ang > 16'sd16384) begin
      red = 17'(ang) - 17'sd32768;
      flip_in = 1'b1;
    end else if (ang < -16'sd16384) begin
      red = 17'(ang) + 17'sd32768;
      flip_in = 1'b1;
    end
  end

  assign dx = y_r >>> step_r;
  assign dy = x_r >>> step_r;
  assign xf = flip_r ? -x_r : x_r;
  assign yf = flip_r ? -y_r : y_r;
  assign cs = (xf > OneQ16) ? OneQ16 : ((xf < -OneQ16) ? -OneQ16 : xf);
  assign sn = (yf > OneQ16) ? OneQ16 : ((yf < -OneQ16) ? -OneQ16 : yf);

  always_comb begin
    state_nxt = state_r;
    step_nxt = step_r;
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    flip_nxt = flip_r;
    mode_nxt = mode_r;
    case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          mode_nxt = mode_t'(in_mode);
          x_nxt = CordicGain;
          y_nxt = '0;
          z_nxt = TrigW'(red);
          flip_nxt = flip_in;
          step_nxt = '0;
          state_nxt = (in_mode == MODE_IDENT) ? F_DONE : F_RUN;
        end
      end
      F_RUN: begin
        if (z_r >= 0) begin
          x_nxt = x_r - dx;
          y_nxt = y_r + dy;
          z_nxt = z_r - atan_lut(step_r);
        end else begin
          x_nxt = x_r + dx;
          y_nxt = y_r - dy;
          z_nxt = z_r + atan_lut(step_r);
        end
        step_nxt = step_r + 1'b1;
        if (step_r == StepW'(CordicSteps - 1)) state_nxt = F_DONE;
      end
      F_DONE: begin
        if (!cmd_stall) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    step_r <= step_nxt;
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    flip_r <= flip_nxt;
    mode_r <= mode_nxt;
  end

  assign in_stall = (state_r != F_IDLE);
  assign cmd_valid = (state_r == F_DONE);
  assign cmd_data = '{mode: mode_r, sin_v: sn, cos_v: cs};
endmodule

// ===== src/omr_back.sv =====
// ----------------------------------------------------------------------------
// omr_back
// Holds the matrix and rotates one row per cycle with two multiply pairs, or resets it to identity.
// ----------------------------------------------------------------------------
`include "orientation_matrix_axis_rotator_macros.svh"
module omr_back import omr_pkg::*; #(
  parameter int ElemWidth = ElemWidthDefault
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cmd_valid,
  input  cmd_t                        cmd_data,
  output logic                        cmd_stall,
  output logic                        out_valid,
  output logic [9*ElemWidth-1:0]      out_mat,
  input  logic                        out_stall
);
  localparam int PW = ElemWidth + TrigW;
  localparam int AW = PW + 1;
  localparam logic signed [ElemWidth-1:0] EMax = {1'b0, {(ElemWidth-1){1'b1}}};
  localparam logic signed [ElemWidth-1:0] EMin = {1'b1, {(ElemWidth-1){1'b0}}};
  localparam logic signed [ElemWidth-1:0] EOne =
    (ElemWidth > FracBits + 1) ? ElemWidth'(65536) : EMax;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_ROW  = 3'b010,
    B_OUT  = 3'b100
  } bstate_t;

  bstate_t state_r, state_nxt;
  logic signed [ElemWidth-1:0] m_r [9];
  logic [1:0] row_r, row_nxt;
  logic [1:0] ca_r, cb_r;
  logic [3:0] idx_a, idx_b;
  logic signed [TrigW-1:0] s_r, c_r;
  logic signed [ElemWidth-1:0] pa, pb, na, nb;
  logic signed [AW-1:0] acc_a, acc_b;

  function automatic logic signed [ElemWidth-1:0] rsat(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] t;
    t = (v + AW'(1 <<< (FracBits - 1))) >>> FracBits;
    if (t > AW'(EMax)) return EMax;
    if (t < AW'(EMin)) return EMin;
    return t[ElemWidth-1:0];
  endfunction

  assign idx_a = 4'(row_r) * 4'd3 + 4'(ca_r);
  assign idx_b = 4'(row_r) * 4'd3 + 4'(cb_r);
  assign pa = m_r[idx_a];
  assign pb = m_r[idx_b];
  assign acc_a = AW'(PW'(c_r) * PW'(pa)) - AW'(PW'(s_r) * PW'(pb));
  assign acc_b = AW'(PW'(c_r) * PW'(pb)) + AW'(PW'(s_r) * PW'(pa));
  assign na = rsat(acc_a);
  assign nb = rsat(acc_b);

  always_comb begin
    state_nxt = state_r;
    row_nxt = row_r;
    case (state_r)
      B_IDLE: if (cmd_valid) begin
        row_nxt = '0;
        state_nxt = (cmd_data.mode == MODE_IDENT) ? B_OUT : B_ROW;
      end
      B_ROW: begin
        row_nxt = row_r + 1'b1;
        if (row_r == 2'd2) state_nxt = B_OUT;
      end
      B_OUT: if (!out_stall) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      for (int k = 0; k < 9; k++) m_r[k] <= (k % 4 == 0) ? EOne : '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_IDLE && cmd_valid) begin
        if (cmd_data.mode == MODE_IDENT) begin
          for (int k = 0; k < 9; k++) m_r[k] <= (k % 4 == 0) ? EOne : '0;
        end
      end else if (state_r == B_ROW) begin
        m_r[idx_a] <= na;
        m_r[idx_b] <= nb;
      end
    end
    row_r <= row_nxt;
    if (state_r == B_IDLE && cmd_valid) begin
      s_r <= cmd_data.sin_v;
      c_r <= cmd_data.cos_v;
      case (cmd_data.mode)
        MODE_PITCH: begin ca_r <= 2'd1; cb_r <= 2'd2; end
        MODE_YAW:   begin ca_r <= 2'd2; cb_r <= 2'd0; end
        default:    begin ca_r <= 2'd1; cb_r <= 2'd0; end
      endcase
    end
  end

  assign cmd_stall = (state_r != B_IDLE);
  assign out_valid = (state_r == B_OUT);
  always_comb begin
    for (int k = 0; k < 9; k++) out_mat[k*ElemWidth +: ElemWidth] = m_r[k];
  end

  `OMR_ASSERT_NEXT(a_row_to_out, clk, rst_n, state_r == B_ROW && row_r == 2'd2, out_valid)
  `OMR_ASSERT_IMPL(a_distinct_cols, clk, rst_n, state_r == B_ROW, ca_r != cb_r)
  `OMR_ASSERT_NEXT(a_hold_out, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_mat))
endmodule

// ===== src/orientation_matrix_axis_rotator.sv =====
// ----------------------------------------------------------------------------
// orientation_matrix_axis_rotator
// Applies pitch/yaw/roll rotations to a stored 3x3 Q2.16 orientation matrix.
// ----------------------------------------------------------------------------
// Channel | Direction | Ports
// in      | input     | in_valid, in_stall, in_mode, in_rotation_angle
// out     | output    | out_valid, out_stall, out_elem_00 .. out_elem_22
// A rotation runs the CORDIC iterations in the front end, then rotates the three rows in
// the back end, one row through two multiplier pairs per cycle.
// The front end takes a new transaction while the back end still works.
// Identity commands skip both loops. Reset is synchronous; matrix = identity.
module orientation_matrix_axis_rotator import omr_pkg::*; #(
  parameter int ElemWidth = ElemWidthDefault
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_mode,
  input  logic signed [15:0]          in_rotation_angle,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [ElemWidth-1:0] out_elem_00,
  output logic signed [ElemWidth-1:0] out_elem_01,
  output logic signed [ElemWidth-1:0] out_elem_02,
  output logic signed [ElemWidth-1:0] out_elem_10,
  output logic signed [ElemWidth-1:0] out_elem_11,
  output logic signed [ElemWidth-1:0] out_elem_12,
  output logic signed [ElemWidth-1:0] out_elem_20,
  output logic signed [ElemWidth-1:0] out_elem_21,
  output logic signed [ElemWidth-1:0] out_elem_22
);
  logic cmd_valid, cmd_stall;
  cmd_t cmd_data;
  logic [9*ElemWidth-1:0] mat;

  omr_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_mode, .in_rotation_angle,
    .cmd_valid, .cmd_data, .cmd_stall
  );

  omr_back #(.ElemWidth(ElemWidth)) u_back (
    .clk, .rst_n, .cmd_valid, .cmd_data, .cmd_stall,
    .out_valid, .out_mat(mat), .out_stall
  );

  assign out_elem_00 = mat[0*ElemWidth +: ElemWidth];
  assign out_elem_01 = mat[1*ElemWidth +: ElemWidth];
  assign out_elem_02 = mat[2*ElemWidth +: ElemWidth];
  assign out_elem_10 = mat[3*ElemWidth +: ElemWidth];
  assign out_elem_11 = mat[4*ElemWidth +: ElemWidth];
  assign out_elem_12 = mat[5*ElemWidth +: ElemWidth];
  assign out_elem_20 = mat[6*ElemWidth +: ElemWidth];
  assign out_elem_21 = mat[7*ElemWidth +: ElemWidth];
  assign out_elem_22 = mat[8*ElemWidth +: ElemWidth];
endmodule
